// ===== src/bounded_ordered_list_store_top_macros.svh =====
// Assertion helpers shared by the list store modules.
`ifndef BOUNDED_ORDERED_LIST_STORE_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_STORE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BLOS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blos assertion failed");
`define BLOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blos assertion failed");
`else
`define BLOS_ASSERT_IMP(label, ante, cons)
`define BLOS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/blos_pkg.sv =====
package blos_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_REMOVE     = 3'd2;
    localparam logic [2:0] OP_SEARCH     = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] value;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] item;
        logic [4:0]         entry_count;
        logic               last;
    } rsp_beat_t;

    typedef struct packed {
        logic      valid;
        rsp_beat_t beat;
    } emit_t;

endpackage

// ===== src/blos_ram.sv =====
module blos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/blos_ctrl.sv =====
`include "bounded_ordered_list_store_top_macros.svh"

module blos_ctrl #(
    parameter int DEPTH = 16,
    parameter int DATA_WIDTH = 32,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  blos_pkg::cmd_beat_t   cmd,
    output blos_pkg::emit_t       emit,
    input  logic                  emit_ready,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [DATA_WIDTH-1:0] ram_wdata,
    output logic [AW-1:0]         ram_raddr,
    input  logic [DATA_WIDTH-1:0] ram_rdata
);

    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] CW_ONE = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DUMP
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [2:0]            op_reg, op_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;

    logic [DATA_WIDTH-1:0] cmd_v;
    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  hit;
    logic                  last_pos;
    logic                  is_push;

    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_X)
        begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    assign cmd_v     = DATA_WIDTH'($unsigned(cmd.value));
    assign cmd_stall = !((state_reg == S_IDLE) && emit_ready);
    assign accept    = cmd_valid && !cmd_stall;
    assign full      = (count_reg == FULL_COUNT);
    assign empty     = (count_reg == '0);
    assign hit       = (ram_rdata == key_reg);
    assign last_pos  = (CW'(pos_reg) == (count_reg - CW_ONE));
    assign is_push   = (cmd.opcode == blos_pkg::OP_PUSH_FRONT) ||
                       (cmd.opcode == blos_pkg::OP_PUSH_BACK);
    assign ram_raddr = wrap_add(head_next, pos_next);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        ram_we     = 1'b0;
        ram_waddr  = head_reg;
        ram_wdata  = cmd_v;
        emit.valid = 1'b0;
        emit.beat.status      = blos_pkg::ST_OK;
        emit.beat.item        = 32'(cmd_v);
        emit.beat.entry_count = 5'(count_reg);
        emit.beat.last        = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                pos_next = '0;
                if (accept)
                begin
                    unique case (cmd.opcode) inside
                        blos_pkg::OP_PUSH_FRONT, blos_pkg::OP_PUSH_BACK:
                        begin
                            emit.valid = 1'b1;
                            if (full)
                            begin
                                emit.beat.status = blos_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW_ONE;
                                if (cmd.opcode == blos_pkg::OP_PUSH_FRONT)
                                begin
                                    head_next = (head_reg == '0) ? LAST_ADDR : head_reg - 1'b1;
                                    ram_waddr = head_next;
                                end
                                else
                                begin
                                    ram_waddr = wrap_add(head_reg, AW'(count_reg));
                                end
                                emit.beat.entry_count = 5'(count_next);
                            end
                        end
                        blos_pkg::OP_REMOVE, blos_pkg::OP_SEARCH:
                        begin
                            if (empty)
                            begin
                                emit.valid = 1'b1;
                                emit.beat.status = blos_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                                op_next    = cmd.opcode;
                                key_next   = cmd_v;
                            end
                        end
                        blos_pkg::OP_DUMP:
                        begin
                            if (empty)
                            begin
                                emit.valid = 1'b1;
                                emit.beat.status = blos_pkg::ST_EMPTY;
                                emit.beat.item   = '0;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                emit.beat.item = 32'(key_reg);
                if (hit || last_pos)
                begin
                    if (emit_ready)
                    begin
                        emit.valid = 1'b1;
                        if (hit && (op_reg == blos_pkg::OP_REMOVE))
                        begin
                            count_next = count_reg - CW_ONE;
                            emit.beat.entry_count = 5'(count_next);
                            if (last_pos)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_SHIFT;
                                pos_next   = pos_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            emit.beat.status = hit ? blos_pkg::ST_OK : blos_pkg::ST_NOT_FOUND;
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                // move the entry at pos up by one to close the gap
                ram_we    = 1'b1;
                ram_waddr = wrap_add(head_reg, pos_reg - 1'b1);
                ram_wdata = ram_rdata;
                if (CW'(pos_reg) == count_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            S_DUMP:
            begin
                emit.beat.item = 32'(ram_rdata);
                emit.beat.last = last_pos;
                if (emit_ready)
                begin
                    emit.valid = 1'b1;
                    if (last_pos)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            op_reg    <= '0;
            key_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            op_reg    <= op_next;
            key_reg   <= key_next;
        end
    end

    `BLOS_ASSERT_IMP(a_emit_has_room, emit.valid, emit_ready)
    `BLOS_ASSERT_NEXT(a_full_push_keeps_count, accept && is_push && full, $stable(count_reg))
    `BLOS_ASSERT_IMP(a_write_source, ram_we, (state_reg == S_SHIFT) || (accept && is_push))

endmodule

// ===== src/blos_out.sv =====
`include "bounded_ordered_list_store_top_macros.svh"

module blos_out (
    input  logic                clk,
    input  logic                rst_n,
    input  blos_pkg::emit_t     emit,
    output logic                emit_ready,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output blos_pkg::rsp_beat_t rsp
);

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    blos_pkg::rsp_beat_t out_reg, out_next;
    blos_pkg::rsp_beat_t skid_reg, skid_next;
    logic                take;

    assign take       = out_valid_reg && !rsp_stall;
    assign emit_ready = !skid_valid_reg;
    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (emit.valid)
            begin
                out_next       = emit.beat;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (emit.valid)
        begin
            // hold the beat while the output is stalled
            skid_next       = emit.beat;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `BLOS_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `BLOS_ASSERT_NEXT(a_stall_fills_skid, out_valid_reg && rsp_stall && emit.valid, skid_valid_reg)

endmodule

// ===== src/bounded_ordered_list_store_top.sv =====
// Bounded ordered list store: up to DEPTH values of DATA_WIDTH bits, head first.
// Command channel (cmd_valid, cmd_stall, cmd): a beat carries an opcode (push front,
// push back, remove first match, search, dump) and a value.
// Response channel (rsp_valid, rsp_stall, rsp): each beat carries status, item,
// entry count after the operation, and last, which marks the final beat of a command.
// Entries sit in one single-port-write, registered-read RAM addressed as a ring.
// How each command runs, from acceptance until the next command can be taken:
//   push, or remove, search or dump on an empty list: answered at once through the output stage.
//   search: reads entries from the head until a match or the last entry.
//   remove: as search, then shifts each entry behind the match to close the gap.
//   dump: one response beat per entry, from the head.
// Scans and dumps read one RAM entry per cycle; dumps advance only while the output stage has room.
// A two-beat output stage lets a command be taken while a response still waits.
// While rsp_stall is high the stage fills and the sequencer holds its place.
// Reset empties the list at once; there is no clearing pass.
module bounded_ordered_list_store_top #(
    parameter int DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  blos_pkg::cmd_beat_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output blos_pkg::rsp_beat_t rsp
);

    localparam int AW = $clog2(DEPTH);

    blos_pkg::emit_t       emit;
    logic                  emit_ready;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    blos_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    blos_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .emit       (emit),
        .emit_ready (emit_ready),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    blos_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .emit_ready (emit_ready),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

// ===== dv/tb_bounded_ordered_list_store_top.sv =====
module tb_bounded_ordered_list_store_top;

    localparam int DEPTH       = 16;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    blos_pkg::cmd_beat_t cmd       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    blos_pkg::rsp_beat_t rsp;

    logic signed [31:0]  list_vals [DEPTH];
    int                  held;
    blos_pkg::rsp_beat_t due_replies [$];

    logic signed [31:0] value_pool [8] = '{32'sd0, -32'sd1, 32'sh7fffffff, 32'sh80000000,
                                           32'sd1, 32'sd5, 32'sd42, -32'sd7};

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int errors      = 0;
    int cmds_sent   = 0;
    int beats_seen  = 0;
    int full_refused = 0;
    int dumps_sent  = 0;

    bounded_ordered_list_store_top #(
        .DEPTH     (DEPTH),
        .DATA_WIDTH(32)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void apply_list_cmd(input blos_pkg::cmd_beat_t c);
        int                  hit;
        blos_pkg::rsp_beat_t r;
        hit = -1;
        r = '0;
        r.item = c.value;
        r.last = 1'b1;
        for (int i = 0; i < held; i++)
            if (hit < 0 && list_vals[i] == c.value)
                hit = i;
        case (c.opcode)
            blos_pkg::OP_PUSH_FRONT, blos_pkg::OP_PUSH_BACK:
            begin
                if (held >= DEPTH)
                begin
                    r.status = blos_pkg::ST_FULL;
                    full_refused++;
                end
                else
                begin
                    if (c.opcode == blos_pkg::OP_PUSH_FRONT)
                    begin
                        for (int i = held; i > 0; i--)
                            list_vals[i] = list_vals[i - 1];
                        list_vals[0] = c.value;
                    end
                    else
                        list_vals[held] = c.value;
                    held++;
                    r.status = blos_pkg::ST_OK;
                end
            end
            blos_pkg::OP_REMOVE:
            begin
                if (hit < 0)
                    r.status = blos_pkg::ST_NOT_FOUND;
                else
                begin
                    for (int i = hit; i + 1 < held; i++)
                        list_vals[i] = list_vals[i + 1];
                    held--;
                    r.status = blos_pkg::ST_OK;
                end
            end
            blos_pkg::OP_SEARCH:
                r.status = (hit < 0) ? blos_pkg::ST_NOT_FOUND : blos_pkg::ST_OK;
            blos_pkg::OP_DUMP:
            begin
                dumps_sent++;
                if (held == 0)
                begin
                    r.status = blos_pkg::ST_EMPTY;
                    r.item = '0;
                end
                else
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        r.status = blos_pkg::ST_OK;
                        r.item = list_vals[i];
                        r.entry_count = held[4:0];
                        r.last = (i == held - 1);
                        due_replies.push_back(r);
                    end
                    return;
                end
            end
            default:
                return;
        endcase
        r.entry_count = held[4:0];
        due_replies.push_back(r);
    endfunction

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (held > 0 && $urandom_range(0, 3) != 0)
            return list_vals[$urandom_range(0, held - 1)];
        return pick_value();
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic signed [31:0] v);
        blos_pkg::cmd_beat_t c;
        c.opcode = op;
        c.value = v;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall !== 1'b0)
            @(posedge clk);
        apply_list_cmd(c);
        cmds_sent++;
    endtask

    task automatic test_empty_list();
        send_cmd(blos_pkg::OP_DUMP, 32'sd0);
        send_cmd(blos_pkg::OP_SEARCH, 32'sd5);
        send_cmd(blos_pkg::OP_REMOVE, -32'sd1);
    endtask

    task automatic test_extreme_values();
        send_cmd(blos_pkg::OP_PUSH_BACK, 32'sh7fffffff);
        send_cmd(blos_pkg::OP_PUSH_FRONT, 32'sh80000000);
        send_cmd(blos_pkg::OP_PUSH_BACK, 32'sd0);
        send_cmd(blos_pkg::OP_PUSH_BACK, -32'sd1);
        send_cmd(blos_pkg::OP_REMOVE, 32'sh80000000);
        send_cmd(blos_pkg::OP_SEARCH, 32'sh80000000);
        send_cmd(blos_pkg::OP_REMOVE, -32'sd1);
    endtask

    task automatic test_unused_opcodes();
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_cmd(op[2:0], 32'sd42);
    endtask

    task automatic test_full_list();
        while (held < DEPTH)
            send_cmd(blos_pkg::OP_PUSH_BACK, 32'sd100 + held);
        send_cmd(blos_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
        send_cmd(blos_pkg::OP_DUMP, 32'sd0);
        send_cmd(blos_pkg::OP_REMOVE, 32'sd100 + DEPTH / 2);
    endtask

    // hold the response side off long enough for the output stage and the list to back up
    task automatic test_backpressure();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_asks++;
        for (int i = 0; i < 40; i++)
        begin
            case ($urandom_range(0, 2))
                0:       send_cmd(blos_pkg::OP_PUSH_BACK, pick_value());
                1:       send_cmd(blos_pkg::OP_SEARCH, pick_key());
                default: send_cmd(blos_pkg::OP_DUMP, 32'sd0);
            endcase
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        int done;
        int push_w;
        int pick;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        done = 0;
        push_w = 50;
        while (done < n)
        begin
            if (done % 25 == 0)
                push_w = $urandom_range(20, 75);
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_cmd(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), pick_value());
            else
            begin
                if ($urandom_range(0, 99) < push_w)
                    send_cmd($urandom_range(0, 1) ? blos_pkg::OP_PUSH_FRONT :
                                                    blos_pkg::OP_PUSH_BACK, pick_value());
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        send_cmd(blos_pkg::OP_REMOVE, pick_key());
                    else if (pick < 8)
                        send_cmd(blos_pkg::OP_SEARCH, pick_key());
                    else
                        send_cmd(blos_pkg::OP_DUMP, pick_value());
                end
                done++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        blos_pkg::rsp_beat_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            beats_seen++;
            if (due_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat status=%0d item=%h count=%0d last=%0d",
                         $time, rsp.status, rsp.item, rsp.entry_count, rsp.last);
            end
            else
            begin
                want = due_replies.pop_front();
                if (rsp.status !== want.status || rsp.item !== want.item ||
                    rsp.entry_count !== want.entry_count || rsp.last !== want.last)
                begin
                    errors++;
                    $display("%0t: mismatch expected status=%0d item=%h count=%0d last=%0d",
                             $time, want.status, want.item, want.entry_count, want.last);
                    $display("%0t:          actual   status=%0d item=%h count=%0d last=%0d",
                             $time, rsp.status, rsp.item, rsp.entry_count, rsp.last);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles, %0d beats still due",
                 $time, QUIET_LIMIT, due_replies.size());
        $display("tb_bounded_ordered_list_store_top NOT OK");
        $finish;
    end

    initial
    begin
        held = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_extreme_values();
        test_unused_opcodes();
        test_full_list();
        test_backpressure();
        test_random_traffic(0, 0, 80);
        test_random_traffic(82, 0, 80);
        test_random_traffic(0, 82, 80);
        test_random_traffic(31, 31, 80);

        cmd_valid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands (%0d dumps, %0d refused as full) and %0d response beats",
                 cmds_sent, dumps_sent, full_refused, beats_seen);
        $display("under free flow, sender gaps, receiver stalls, both, and one long receiver hold");
        if (errors == 0)
            $display("tb_bounded_ordered_list_store_top OK");
        else
            $display("tb_bounded_ordered_list_store_top NOT OK");
        $finish;
    end

endmodule
